FILE: rtl/gaussian_blur_3x3_rgb_defines.svh
// Assertion macros for the 3x3 RGB blur.
// Taken in by the top level; needs nothing else.
`ifndef GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gb3_pkg.sv
// Shared types and constants of the 3x3 RGB blur.
// No dependencies; used by the channel interfaces, the normalizer and the top level.
package gb3_pkg;

    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;
    localparam int ROW_W        = HEIGHT_REG_W + 1;
    localparam int SUM_W        = 12;
    localparam int SHIFT_W      = 3;
    localparam int RECIP_W      = 12;
    localparam int RSH_W        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    typedef logic [1:0] t_div_code;
    localparam t_div_code DIV_BY_ONE   = 2'd0;
    localparam t_div_code DIV_BY_THREE = 2'd1;
    localparam t_div_code DIV_BY_NINE  = 2'd2;

    // x / 3 == (x * 2731) >> 13 for x < 8192; x / 9 == (x * 3641) >> 15 for x < 32768
    localparam logic [RECIP_W-1:0] RECIP_THREE = 12'd2731;
    localparam logic [RECIP_W-1:0] RECIP_NINE  = 12'd3641;
    localparam logic [RSH_W-1:0]   RSH_THREE   = 4'd13;
    localparam logic [RSH_W-1:0]   RSH_NINE    = 4'd15;

    // chan0 in [0], chan1 in [1], chan2 in [2]
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        t_div_code          div;
    } t_norm_ctl;

endpackage

FILE: rtl/gb3_ifs.sv
// Valid/ready channel interfaces of the 3x3 RGB blur: pixel in, pixel out, config writes.
// Depends on gb3_pkg for the config port widths.
interface gb3_pix_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;

    modport source (output valid, kind, in_chan0, in_chan1, in_chan2, input ready);
    modport sink   (input valid, kind, in_chan0, in_chan1, in_chan2, output ready);
endinterface

interface gb3_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic       frame_end;

    modport source (output valid, out_chan0, out_chan1, out_chan2, frame_end, input ready);
    modport sink   (input valid, out_chan0, out_chan1, out_chan2, frame_end, output ready);
endinterface

interface gb3_cfg_if;
    import gb3_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/gb3_norm.sv
// Normalizer for one channel: divides a weighted sum by 2^a * 3^b, truncating.
// Depends on gb3_pkg for the control struct and reciprocal constants.
module gb3_norm (
    input  logic [gb3_pkg::SUM_W-1:0] i_sum,
    input  gb3_pkg::t_norm_ctl        i_ctl,
    output logic [7:0]                o_q
);
    import gb3_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [SUM_W-1:0]   x;
    logic [RECIP_W-1:0] mult;
    logic [RSH_W-1:0]   rsh;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  quo;

    assign x = i_sum >> i_ctl.shift;

    always_comb begin
        unique case (i_ctl.div)
            DIV_BY_THREE: begin
                mult = RECIP_THREE;
                rsh  = RSH_THREE;
            end
            DIV_BY_NINE: begin
                mult = RECIP_NINE;
                rsh  = RSH_NINE;
            end
            default: begin
                mult = RECIP_W'(1);
                rsh  = '0;
            end
        endcase
    end

    assign prod = PROD_W'(x) * PROD_W'(mult);
    assign quo  = prod >> rsh;
    assign o_q  = quo[7:0];

endmodule

FILE: rtl/gaussian_blur_3x3_rgb.sv
// 3x3 Gaussian blur (1,2,1 / 2,4,2 / 1,2,1) over an RGB raster stream, per channel.
// Depends on gb3_pkg, gb3_ifs (channel interfaces), gb3_norm and the defines header.
//
// Usage:
//   i_pix  : pixel requests in raster order; kind 0 carries a pixel, kind 1 is a
//            flush tick. After the last pixel of a frame, width + 1 flush ticks
//            (pixels are treated as ticks there) drain the pending results.
//   o_pix  : filtered pixels, one row and one column behind the input; frame_end
//            marks the last one of the frame.
//   i_cfg  : register writes (0 image_width, 1 image_height); a write to either
//            restarts the frame and drops pending results. Write only while idle.
// Steps: a flush tick inside the frame is taken and dropped. Any other item is latched
//   with the read of the row memories at its column; the EXEC step updates the window
//   and forms the weighted sums, and for an item that yields a result the DIV step
//   normalizes them into the output register.
// A new request is taken while a finished result waits in the output register;
//   when the receiver stalls, the block holds in its normalize step after that.
// Reset sets 640 x 480 and an empty frame; row memories are not cleared.
`include "gaussian_blur_3x3_rgb_defines.svh"

module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gb3_pix_in_if.sink    i_pix,
    gb3_pix_out_if.source o_pix,
    gb3_cfg_if.sink       i_cfg
);
    import gb3_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMPW   = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int DONE_W = WW + HEIGHT_REG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // configuration and frame position
    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [DONE_W-1:0]       r_total;
    logic [AW-1:0]           r_in_column;
    logic [ROW_W-1:0]        r_in_row;
    logic [DONE_W-1:0]       r_out_done;
    logic [1:0]              r_state;
    logic [1:0]              n_state;

    // row memories
    t_rgb r_row_upper  [MAX_WIDTH];
    t_rgb r_row_middle [MAX_WIDTH];
    t_rgb r_up_rd;
    t_rgb r_mid_rd;

    // per-item context
    t_rgb          r_pix;
    logic [AW-1:0] r_col;
    logic          r_emit;
    logic          r_frame_end;
    logic          r_top;
    logic          r_bot;
    logic          r_left;
    logic          r_right;

    // window: left and centre columns, rows top/middle/bottom
    t_rgb r_win_l [3];
    t_rgb r_win_c [3];
    t_rgb new_col [3];

    logic [SUM_W-1:0] r_sum [3];
    logic [SUM_W-1:0] sums  [3];
    t_norm_ctl        r_norm_ctl;
    t_norm_ctl        n_norm_ctl;
    logic             r_div_frame_end;
    logic [7:0]       norm_q [3];

    logic       r_out_valid;
    logic [7:0] r_out_q [3];
    logic       r_out_frame_end;

    // combinational helpers
    logic [CMPW-1:0]         width_ext;
    logic [WW-1:0]           eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic                    in_fire;
    logic                    cfg_fire;
    logic                    draining;
    logic                    ignore;
    logic                    first_blur;
    logic                    second_blur;
    logic                    emit;
    logic                    frame_end;
    logic [ROW_W-1:0]        row_m1;
    logic [WW-1:0]           col_inc;
    logic                    wrap;
    logic                    out_load;
    logic [2:0]              row_inc;
    logic [9:0]              row_val [3][3];
    logic                    r_half;
    logic                    r_third;
    logic                    c_half;
    logic                    c_third;

    assign width_ext = CMPW'(r_image_width);

    always_comb begin
        if (width_ext == '0) begin
            eff_w = WW'(1);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_ext);
        end
    end

    assign eff_h = (r_image_height == '0) ? HEIGHT_REG_W'(1) : r_image_height;

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_pix.valid && i_pix.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    // decisions for the request at the current position
    assign draining    = r_in_row >= ROW_W'(eff_h);
    assign ignore      = !draining && i_pix.kind;
    assign first_blur  = (r_in_column == '0) && (r_in_row >= ROW_W'(2));
    assign second_blur = (r_in_column != '0) && (r_in_row != '0);
    assign emit        = first_blur || second_blur;
    assign frame_end   = emit && ((r_out_done + DONE_W'(1)) == r_total);
    assign row_m1      = r_in_row - ROW_W'(1);
    assign col_inc     = WW'(r_in_column) + WW'(1);
    assign wrap        = col_inc >= eff_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_in_column    <= '0;
            r_in_row       <= '0;
            r_out_done     <= '0;
        end else if (cfg_fire) begin
            if (i_cfg.index == REG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg.data[WIDTH_REG_W-1:0];
                r_in_column   <= '0;
                r_in_row      <= '0;
                r_out_done    <= '0;
            end else if (i_cfg.index == REG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg.data;
                r_in_column    <= '0;
                r_in_row       <= '0;
                r_out_done     <= '0;
            end
        end else if (in_fire && !ignore) begin
            if (frame_end) begin
                r_in_column <= '0;
                r_in_row    <= '0;
                r_out_done  <= '0;
            end else begin
                r_in_column <= wrap ? '0 : col_inc[AW-1:0];
                r_in_row    <= wrap ? (r_in_row + ROW_W'(1)) : r_in_row;
                r_out_done  <= r_out_done + DONE_W'(emit);
            end
        end
    end

    // frame size follows the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_total <= DONE_W'(eff_w) * DONE_W'(eff_h);
    end

    // latch the request and read both row memories at its column
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_up_rd     <= r_row_upper[r_in_column];
            r_mid_rd    <= r_row_middle[r_in_column];
            r_pix       <= draining ? '0 : {i_pix.in_chan2, i_pix.in_chan1, i_pix.in_chan0};
            r_col       <= r_in_column;
            r_emit      <= emit;
            r_frame_end <= frame_end;
            r_top       <= first_blur ? (r_in_row >= ROW_W'(3)) : (r_in_row >= ROW_W'(2));
            r_bot       <= first_blur ? (row_m1 < ROW_W'(eff_h)) : !draining;
            r_left      <= first_blur ? (eff_w >= WW'(2)) : (WW'(r_in_column) >= WW'(2));
            r_right     <= !first_blur;
        end
    end

    // write back: the middle row moves up, the new sample becomes the middle row
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_row_upper[r_col]  <= r_mid_rd;
            r_row_middle[r_col] <= r_pix;
        end
    end

    assign new_col[0] = r_up_rd;
    assign new_col[1] = r_mid_rd;
    assign new_col[2] = r_pix;
    assign row_inc    = {r_bot, 1'b1, r_top};

    // weighted sums: left and centre taps come from the window, the right tap is new
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sums[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                row_val[ch][r] = (r_left ? 10'(r_win_l[r][ch]) : 10'd0)
                               + (10'(r_win_c[r][ch]) << 1)
                               + (r_right ? 10'(new_col[r][ch]) : 10'd0);
                if (row_inc[r]) begin
                    sums[ch] = sums[ch] + ((r == 1) ? (SUM_W'(row_val[ch][r]) << 1)
                                                    : SUM_W'(row_val[ch][r]));
                end
            end
        end
    end

    // weight total = (2 + top + bot) * (2 + left + right), split into 2^a * 3^b
    assign r_third = r_top ^ r_bot;
    assign r_half  = !r_top && !r_bot;
    assign c_third = r_left ^ r_right;
    assign c_half  = !r_left && !r_right;

    always_comb begin
        n_norm_ctl.shift = SHIFT_W'(r_top && r_bot) * SHIFT_W'(2) + SHIFT_W'(r_half)
                         + SHIFT_W'(r_left && r_right) * SHIFT_W'(2) + SHIFT_W'(c_half);
        if (r_third && c_third) begin
            n_norm_ctl.div = DIV_BY_NINE;
        end else if (r_third || c_third) begin
            n_norm_ctl.div = DIV_BY_THREE;
        end else begin
            n_norm_ctl.div = DIV_BY_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win_l[r] <= '0;
                r_win_c[r] <= '0;
            end
        end else if (r_state == S_EXEC) begin
            for (int r = 0; r < 3; r++) begin
                r_win_l[r] <= r_win_c[r];
                r_win_c[r] <= new_col[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sum[ch] <= sums[ch];
            end
            r_norm_ctl      <= n_norm_ctl;
            r_div_frame_end <= r_frame_end;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_norm
        gb3_norm u_norm (
            .i_sum (r_sum[ch]),
            .i_ctl (r_norm_ctl),
            .o_q   (norm_q[ch])
        );
    end

    assign out_load = (r_state == S_DIV) && (!r_out_valid || o_pix.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && !ignore) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_q[ch] <= norm_q[ch];
            end
            r_out_frame_end <= r_div_frame_end;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_chan0 = r_out_q[0];
    assign o_pix.out_chan1 = r_out_q[1];
    assign o_pix.out_chan2 = r_out_q[2];
    assign o_pix.frame_end = r_out_frame_end;

    `GB3_ASSERT_NOW(a_col_in_frame, i_clk, i_rst_n, 1'b1, WW'(r_in_column) < eff_w, "column beyond frame width")
    `GB3_ASSERT_NEXT(a_div_drains, i_clk, i_rst_n, out_load, r_out_valid && (r_state == S_IDLE), "normalized result not loaded")
    `GB3_ASSERT_NOW(a_frame_restart, i_clk, i_rst_n, (r_state == S_EXEC) && r_frame_end, (r_in_row == '0) && (r_in_column == '0) && (r_out_done == '0), "frame counters not cleared at frame end")

endmodule
